[rtl/core/pta_pkg.sv]
`default_nettype none

package pta_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [CFG_W-1:0] RESET_PURGE_INTERVAL = CFG_W'(60);
    localparam logic [CFG_W-1:0] RESET_ENTRY_TIMEOUT  = CFG_W'(60 * 5);

    // Register select, taken from paddr[2]
    localparam logic REG_PURGE_INTERVAL = 1'b0;
    localparam logic REG_ENTRY_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        MODE_FIND  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_PURGE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_SKIP = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] seen;
        logic [PORT_W-1:0] port;
        logic [IP_W-1:0]   ip;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        mode_t             mode;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic [CFG_W-1:0] purge_interval;
        logic [CFG_W-1:0] entry_timeout;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] occupancy;
        logic [COUNT_W-1:0] removed;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
    } res_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

endpackage

`default_nettype wire

[rtl/core/pta_ram.sv]
`default_nettype none

module pta_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 80,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/pta_regs.sv]
`default_nettype none

module pta_regs
    import pta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_stb) begin
            case (paddr[2])
                REG_PURGE_INTERVAL: cfg_next.purge_interval = pwdata[CFG_W-1:0];
                REG_ENTRY_TIMEOUT:  cfg_next.entry_timeout  = pwdata[CFG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.purge_interval <= RESET_PURGE_INTERVAL;
            cfg_reg.entry_timeout  <= RESET_ENTRY_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PURGE_INTERVAL: prdata = 32'(cfg_reg.purge_interval);
            REG_ENTRY_TIMEOUT:  prdata = 32'(cfg_reg.entry_timeout);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/pta_engine.sv]
`default_nettype none

module pta_engine
    import pta_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t req,
    input  wire cfg_t cfg,
    output mem_req_t  mem,
    input  wire entry_t rd_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res
);

    state_t state_reg, state_next;

    req_t                req_reg, req_next;
    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    match_reg, match_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]   last_purge_reg, last_purge_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    res_t                res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    res_t                m_res_reg, m_res_next;

    logic                accept;
    logic                too_soon;
    logic                scan_done;
    logic                out_free;
    logic                entry_vld;
    logic                key_eq;
    logic [TIME_W-1:0]   age;

    assign accept    = s_valid && s_ready;
    assign too_soon  = (req.now - last_purge_reg) < TIME_W'(cfg.purge_interval);
    assign scan_done = (iss_reg == CNT_W'(TABLE_DEPTH)) && !chk_vld_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign entry_vld = valid_reg[chk_idx_reg];
    assign key_eq    = (rd_data.ip == req_reg.ip) && (rd_data.port == req_reg.port);
    assign age       = req_reg.now - rd_data.seen;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req.mode == MODE_CLEAR || (req.mode == MODE_PURGE && too_soon)) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        req_next        = req_reg;
        iss_next        = iss_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        removed_next    = removed_reg;
        count_next      = count_reg;
        last_purge_next = last_purge_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_res_next      = m_res_reg;
        s_ready         = 1'b0;
        mem             = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    req_next        = req;
                    iss_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    res_next        = '0;
                    res_next.status = STATUS_DONE;
                    if (req.mode == MODE_CLEAR) begin
                        // Drop every entry at once
                        res_next.removed = COUNT_W'(count_reg);
                        count_next       = '0;
                        valid_next       = '0;
                    end else if (req.mode == MODE_PURGE && too_soon) begin
                        res_next.status = STATUS_SKIP;
                    end
                end
            end
            ST_SCAN: begin
                // Issue reads in ascending order
                if (iss_reg != CNT_W'(TABLE_DEPTH)) begin
                    mem.rd_en    = 1'b1;
                    mem.rd_addr  = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg[IDX_W-1:0];
                end
                // Check the entry read in the previous cycle
                if (chk_vld_reg) begin
                    if (req_reg.mode == MODE_PURGE) begin
                        if (entry_vld && age > TIME_W'(cfg.entry_timeout)) begin
                            valid_next[chk_idx_reg] = 1'b0;
                            removed_next            = removed_reg + 1'b1;
                            count_next              = count_reg - 1'b1;
                        end
                    end else begin
                        if (entry_vld && key_eq && !found_reg) begin
                            found_next = 1'b1;
                            match_next = chk_idx_reg;
                        end
                        if (!entry_vld && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_next       = chk_idx_reg;
                        end
                    end
                end
            end
            ST_COMMIT: begin
                case (req_reg.mode)
                    MODE_FIND: begin
                        if (found_reg) begin
                            res_next.hit  = 1'b1;
                            res_next.slot = SLOT_W'(match_reg);
                        end
                    end
                    MODE_ADD: begin
                        mem.wr_data.ip   = req_reg.ip;
                        mem.wr_data.port = req_reg.port;
                        mem.wr_data.seen = req_reg.now;
                        if (found_reg) begin
                            // Refresh the stamp of the present key
                            mem.wr_en     = 1'b1;
                            mem.wr_addr   = match_reg;
                            res_next.hit  = 1'b1;
                            res_next.slot = SLOT_W'(match_reg);
                        end else if (free_found_reg) begin
                            mem.wr_en             = 1'b1;
                            mem.wr_addr           = free_reg;
                            valid_next[free_reg]  = 1'b1;
                            count_next            = count_reg + 1'b1;
                            res_next.slot         = SLOT_W'(free_reg);
                        end else begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    MODE_PURGE: begin
                        res_next.removed = COUNT_W'(removed_reg);
                        last_purge_next  = req_reg.now;
                    end
                    default: res_next = res_reg;
                endcase
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_res_next           = res_reg;
                    m_res_next.occupancy = COUNT_W'(count_reg);
                end
            end
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            chk_vld_reg    <= 1'b0;
            count_reg      <= '0;
            last_purge_reg <= '0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            chk_vld_reg    <= chk_vld_next;
            count_reg      <= count_next;
            last_purge_reg <= last_purge_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        iss_reg        <= iss_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        match_reg      <= match_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        removed_reg    <= removed_next;
        res_reg        <= res_next;
        m_res_reg      <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

`default_nettype wire

[rtl/core/peer_table_with_aging_top.sv]
`default_nettype none

// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tdata: peer_ip, peer_port, now_seconds; s_tuser: mode
// m_       out  m_tvalid / m_tready  m_tdata: hit, slot, removed, occupancy, status
// APB      in   psel/penable/pwrite  0x0 purge_interval, 0x4 entry_timeout
//
// Find, add and an effective purge read every entry in turn through the single read
// port, check each entry after its read, close the scan, commit, and then load the
// output register once it is free; the next request is taken after that. Clear and
// a purge that comes too soon go from idle straight to the response state and load
// their result there once the output register is free.
// Reset clears the valid bits, occupancy and last purge time at once; no sweep.
// A new request is taken while the previous result waits in the output register;
// the result of that request holds until the output register is free.

module peer_table_with_aging_top
    import pta_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // [31:0] peer_ip, [47:32] peer_port, [79:48] now_seconds
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] hit, [6:1] slot, [13:7] removed,
                                        // [20:14] occupancy, [22:21] status, [23] zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t     cfg;
    req_t     req;
    res_t     res;
    mem_req_t mem;
    entry_t   rd_data;

    // Unpack the request
    assign req.ip   = s_tdata[31:0];
    assign req.port = s_tdata[47:32];
    assign req.now  = s_tdata[79:48];
    assign req.mode = mode_t'(s_tuser);

    pta_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pta_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data)
    );

    pta_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .req     (req),
        .cfg     (cfg),
        .mem     (mem),
        .rd_data (rd_data),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // Pack the result
    assign m_tdata = {1'b0, res.status, res.occupancy, res.removed, res.slot, res.hit};

endmodule

`default_nettype wire
